>>> sv/vfd_pkg.sv
// Shared types and codes for the varint frame deframer.
// Used by vfd_front, vfd_queue, vfd_back and varint_frame_deframer.
package vfd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_SHORT     = 3'd0;
    localparam logic [2:0] ERR_PREAMBLE  = 3'd1;
    localparam logic [2:0] ERR_NO_SIZE   = 3'd2;
    localparam logic [2:0] ERR_NO_TYPE   = 3'd3;
    localparam logic [2:0] ERR_MISMATCH  = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [31:0] frame_size;
        logic [31:0] frame_type;
        logic [2:0]  error_code;
        logic        payload_last;
    } vfd_result_t;

    // trunc: a truncated-payload error follows this result
    typedef struct packed {
        logic        trunc;
        vfd_result_t res;
    } vfd_entry_t;

    typedef struct packed {
        logic       valid;
        vfd_entry_t entry;
    } vfd_push_t;

endpackage

>>> sv/vfd_front.sv
// Front part of the deframer: accepts bytes, decodes the varint header and
// classifies each byte into at most one queue entry. Depends on vfd_pkg.
module vfd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // data_byte
    input  logic              s_axis_tlast,   // chunk_end
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,      // expected_type
    input  logic              q_full,
    output vfd_pkg::vfd_push_t push
);
    import vfd_pkg::*;

    typedef enum logic [2:0] {
        PH_PREAMBLE = 3'd0,
        PH_SIZE     = 3'd1,
        PH_TYPE     = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_DROP     = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next, ph_work;
    logic [31:0] accum_reg, accum_next;
    logic [2:0]  vbytes_reg, vbytes_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] remain_reg, remain_next;
    logic [1:0]  ccount_reg, ccount_next;
    logic [31:0] exp_type_reg;

    logic        accept;
    logic [1:0]  cc_inc;
    logic [4:0]  shamt;
    logic [31:0] accum_or;
    vfd_entry_t  ent;
    logic        emit;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign cc_inc        = (ccount_reg == 2'd3) ? ccount_reg : ccount_reg + 2'd1;

    always_comb
    begin
        case (vbytes_reg)
            3'd1:    shamt = 5'd7;
            3'd2:    shamt = 5'd14;
            3'd3:    shamt = 5'd21;
            3'd4:    shamt = 5'd28;
            default: shamt = 5'd0;
        endcase
    end

    assign accum_or = accum_reg | ({25'd0, s_axis_tdata[6:0]} << shamt);

    always_comb
    begin
        ph_work     = phase_reg;
        accum_next  = accum_reg;
        vbytes_next = vbytes_reg;
        size_next   = size_reg;
        remain_next = remain_reg;
        ccount_next = ccount_reg;
        ent         = '0;
        emit        = 1'b0;
        if (accept)
        begin
            ccount_next = cc_inc;
            if (phase_reg == PH_DROP)
            begin
            end
            else if (s_axis_tlast && cc_inc != 2'd3)
            begin
                emit               = 1'b1;
                ent.res.kind       = KIND_ERROR;
                ent.res.error_code = ERR_SHORT;
                ph_work            = PH_DROP;
            end
            else
            begin
                unique case (phase_reg)
                    PH_PAYLOAD:
                    begin
                        remain_next          = remain_reg - 32'd1;
                        emit                 = 1'b1;
                        ent.res.kind         = KIND_PAYLOAD;
                        ent.res.payload_byte = s_axis_tdata;
                        if (remain_reg == 32'd1)
                        begin
                            ent.res.payload_last = 1'b1;
                            ph_work              = PH_DROP;
                        end
                        else
                        begin
                            ent.trunc = s_axis_tlast;
                        end
                    end
                    PH_PREAMBLE, PH_SIZE, PH_TYPE:
                    begin
                        if (s_axis_tdata[7])
                        begin
                            if (vbytes_reg >= 3'd4)
                            begin
                                emit               = 1'b1;
                                ent.res.kind       = KIND_ERROR;
                                ent.res.error_code = ERR_OVERFLOW;
                                ph_work            = PH_DROP;
                            end
                            else
                            begin
                                accum_next  = accum_or;
                                vbytes_next = vbytes_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            accum_next  = '0;
                            vbytes_next = '0;
                            if (phase_reg == PH_PREAMBLE)
                            begin
                                if (accum_or != 32'd0)
                                begin
                                    emit               = 1'b1;
                                    ent.res.kind       = KIND_ERROR;
                                    ent.res.error_code = ERR_PREAMBLE;
                                    ph_work            = PH_DROP;
                                end
                                else
                                begin
                                    ph_work = PH_SIZE;
                                end
                            end
                            else if (phase_reg == PH_SIZE)
                            begin
                                size_next = accum_or;
                                ph_work   = PH_TYPE;
                            end
                            else if (accum_or != exp_type_reg)
                            begin
                                emit               = 1'b1;
                                ent.res.kind       = KIND_ERROR;
                                ent.res.error_code = ERR_MISMATCH;
                                ent.res.frame_type = accum_or;
                                ph_work            = PH_DROP;
                            end
                            else
                            begin
                                emit                 = 1'b1;
                                ent.res.kind         = KIND_HEADER;
                                ent.res.frame_size   = size_reg;
                                ent.res.frame_type   = accum_or;
                                ent.res.payload_last = (size_reg == 32'd0);
                                if (size_reg == 32'd0)
                                begin
                                    ph_work = PH_DROP;
                                end
                                else
                                begin
                                    remain_next = size_reg;
                                    ph_work     = PH_PAYLOAD;
                                    ent.trunc   = s_axis_tlast;
                                end
                            end
                        end
                        if (s_axis_tlast && ph_work == PH_PREAMBLE)
                        begin
                            emit               = 1'b1;
                            ent.res.kind       = KIND_ERROR;
                            ent.res.error_code = ERR_PREAMBLE;
                        end
                        else if (s_axis_tlast && ph_work == PH_SIZE)
                        begin
                            emit               = 1'b1;
                            ent.res.kind       = KIND_ERROR;
                            ent.res.error_code = ERR_NO_SIZE;
                        end
                        else if (s_axis_tlast && ph_work == PH_TYPE)
                        begin
                            emit               = 1'b1;
                            ent.res.kind       = KIND_ERROR;
                            ent.res.error_code = ERR_NO_TYPE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (s_axis_tlast)
            begin
                ph_work     = PH_PREAMBLE;
                accum_next  = '0;
                vbytes_next = '0;
                ccount_next = '0;
            end
        end
        phase_next = ph_work;
    end

    assign push.valid = emit;
    assign push.entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PREAMBLE;
            accum_reg    <= '0;
            vbytes_reg   <= '0;
            size_reg     <= '0;
            remain_reg   <= '0;
            ccount_reg   <= '0;
            exp_type_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            vbytes_reg <= vbytes_next;
            size_reg   <= size_next;
            remain_reg <= remain_next;
            ccount_reg <= ccount_next;
            if (cfg_we)
            begin
                exp_type_reg <= cfg_wdata;
            end
        end
    end

endmodule

>>> sv/vfd_queue.sv
// Short entry queue between the front and back parts of the deframer.
// Depends on vfd_pkg.
module vfd_queue #(
    parameter int DEPTH = vfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  vfd_pkg::vfd_push_t  push,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output vfd_pkg::vfd_entry_t head
);
    import vfd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    vfd_entry_t    mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/vfd_back.sv
// Back part of the deframer: drains queue entries into the output register,
// expanding a trailing truncated-payload error. Depends on vfd_pkg.
module vfd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  vfd_pkg::vfd_entry_t q_head,
    output logic                q_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [79:0]         m_axis_tdata,
    output logic [1:0]          m_axis_tuser,
    output logic                m_axis_tlast
);
    import vfd_pkg::*;

    logic        valid_reg, valid_next;
    logic        pend_reg, pend_next;
    logic        last_reg, last_next;
    vfd_result_t res_reg, res_next;
    logic        load_free;

    assign load_free = !valid_reg || m_axis_tready;
    assign q_pop     = load_free && !pend_reg && !q_empty;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        last_next  = last_reg;
        res_next   = res_reg;
        if (load_free)
        begin
            if (pend_reg)
            begin
                valid_next          = 1'b1;
                pend_next           = 1'b0;
                last_next           = 1'b1;
                res_next            = '0;
                res_next.kind       = KIND_ERROR;
                res_next.error_code = ERR_TRUNCATED;
            end
            else if (!q_empty)
            begin
                valid_next = 1'b1;
                pend_next  = q_head.trunc;
                last_next  = !q_head.trunc;
                res_next   = q_head.res;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {4'd0, res_reg.payload_last, res_reg.error_code,
                            res_reg.frame_type, res_reg.frame_size, res_reg.payload_byte};

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

>>> sv/varint_frame_deframer.sv
// Varint length-prefixed frame deframer, top level.
// Depends on vfd_pkg, vfd_front, vfd_queue and vfd_back.
//
// Takes one byte per cycle while s_axis_tready is high. The front part decodes
// each byte combinationally into at most one queue entry; the back part sends
// one result per cycle while m_axis_tready is high. A byte that ends a chunk
// while payload is still due gives two results (the header or payload byte,
// then a truncated-payload error), both sent before the next entry is taken.
// A QUEUE_DEPTH-entry queue sits between the parts; s_axis_tready drops only
// while it is full. The user must write expected_type through cfg_we/cfg_wdata
// only while no frame is in flight; the block itself does not enforce this.
module varint_frame_deframer #(
    parameter int QUEUE_DEPTH = vfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // chunk_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [39:8] frame_size, [71:40] frame_type,
    // [74:72] error_code, [75] payload_last, [79:76] zero
    output logic [79:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,   // last
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata       // expected_type
);
    import vfd_pkg::*;

    vfd_push_t  push;
    vfd_entry_t q_head;
    logic       q_full, q_empty, q_pop;

    vfd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_full        (q_full),
        .push          (push)
    );

    vfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (q_head)
    );

    vfd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_ERROR |-> m_axis_tlast)
        else $error("error result not marked last");

    a_header_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_HEADER && m_axis_tdata[75]
        |-> m_axis_tdata[39:8] == 32'd0)
        else $error("header flagged last with nonzero size");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD
        |-> m_axis_tdata[74:8] == 67'd0)
        else $error("payload result carries header or error fields");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !s_axis_tready)
        else $error("input ready while queue full");

endmodule
